>>> sv/tqps_pkg.sv
// shared constants and types for the three-queue priority select
package tqps_pkg;
  localparam int QueueDepth = 256;
  localparam int NumQueues  = 3;
  localparam int PrioBits   = 8;
  localparam int IdBits     = 16;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_WAIT,
    S_UP_CMP,
    S_DN_LAST,
    S_DN_LWAIT,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_WAITR,
    S_DN_CMP,
    S_DN_FIN,
    S_OUT
  } fsm_t;
endpackage

>>> sv/three_queue_stable_priority_select_top.sv
// three stable priority queues built as binary heaps in one memory
//
//   channel | ports                                | direction
//   in      | in_valid in_stall in_mode in_queue_sel in_priority_req | beat in
//   out     | out_valid out_stall out_status out_entry_id           | beat out
//
// insert walks up to log2(QUEUE_DEPTH) levels via S_UP_RD, S_UP_WAIT, S_UP_CMP
// remove fetches the last entry, then walks down up to log2(QUEUE_DEPTH) levels
// one memory port pair sets the walk: one read, one write per cycle
// clear, nop and refused beats go from S_IDLE straight to S_OUT
// reset empties all queues via counts; heap memory is never cleared
// in_stall is high while a beat is in work or a result waits on out_stall
module three_queue_stable_priority_select_top #(
  parameter int QUEUE_DEPTH = tqps_pkg::QueueDepth,
  parameter int NUM_QUEUES  = tqps_pkg::NumQueues,
  parameter int PRIO_BITS   = tqps_pkg::PrioBits,
  parameter int ID_BITS     = tqps_pkg::IdBits
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [1:0] in_queue_sel,
  input  logic [7:0] in_priority_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [15:0] out_entry_id
);
  import tqps_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int MD = NUM_QUEUES * QUEUE_DEPTH;
  localparam int MW = $clog2(MD);
  localparam int EW = PRIO_BITS + ID_BITS;

  typedef struct packed {
    logic [PRIO_BITS-1:0] prio;
    logic [ID_BITS-1:0]   id;
  } ent_t;

  logic [EW-1:0] mem [MD];
  logic [MW-1:0] rd_addr;
  logic [MW-1:0] wr_addr;
  logic          wr_en;
  ent_t          wr_data;
  ent_t          rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  fsm_t state_r, state_nxt;
  logic [CW-1:0] cnt_r [NUM_QUEUES];
  logic [ID_BITS:0] next_id_r;
  logic [QW-1:0] q_r;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] n_r;
  ent_t cur_r;
  ent_t lft_r;
  logic [1:0]  status_r;
  logic [15:0] id_r;
  logic        out_valid_r;

  function automatic logic first(ent_t a, ent_t b);
    if (a.prio != b.prio) return a.prio > b.prio;
    return a.id < b.id;
  endfunction

  function automatic logic [MW-1:0] addr(logic [QW-1:0] q, logic [AW-1:0] p);
    return MW'(q) * MW'(QUEUE_DEPTH) + MW'(p);
  endfunction

  logic [QW-1:0] sel_q;
  always_comb begin
    if (in_queue_sel == 2'd0 || 32'(in_queue_sel) > NUM_QUEUES) begin
      sel_q = QW'(NUM_QUEUES - 1);
    end else begin
      sel_q = QW'(in_queue_sel - 2'd1);
    end
  end

  logic accept;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_entry_id = id_r;

  // heap index math
  logic [AW-1:0] parent;
  logic [CW:0]   left_c;
  logic [CW:0]   right_c;
  assign parent  = AW'((pos_r - AW'(1)) >> 1);
  assign left_c  = (CW+1)'({pos_r, 1'b1});
  assign right_c = left_c + (CW+1)'(1);

  logic [CW-1:0] cnt_sel;
  assign cnt_sel = cnt_r[sel_q];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (mode_t'(in_mode) == MODE_INSERT && next_id_r <= (ID_BITS+1)'((1 << ID_BITS) - 1)
              && 32'(cnt_sel) < QUEUE_DEPTH) begin
            state_nxt = S_UP_RD;
          end else if (mode_t'(in_mode) == MODE_REMOVE && cnt_sel != '0) begin
            state_nxt = S_DN_LAST;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_UP_RD:    state_nxt = (pos_r == '0) ? S_OUT : S_UP_WAIT;
      S_UP_WAIT:  state_nxt = S_UP_CMP;
      S_UP_CMP:   state_nxt = first(cur_r, rd_data) ? S_UP_RD : S_OUT;
      S_DN_LAST:  state_nxt = S_DN_LWAIT;
      S_DN_LWAIT: state_nxt = S_DN_RDL;
      S_DN_RDL:   state_nxt = (left_c >= (CW+1)'(n_r)) ? S_DN_FIN : S_DN_RDR;
      S_DN_RDR:   state_nxt = S_DN_WAITR;
      S_DN_WAITR: state_nxt = S_DN_CMP;
      S_DN_CMP:   state_nxt = first(best, cur_r) ? S_DN_RDL : S_DN_FIN;
      S_DN_FIN:   state_nxt = S_OUT;
      S_OUT:      state_nxt = (out_valid_r && !out_stall) ? S_IDLE : S_OUT;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath control
  ent_t best;
  logic [AW-1:0] best_pos;
  logic has_r;
  logic has_r_r;
  assign has_r = right_c < (CW+1)'(n_r);
  always_comb begin
    best = lft_r;
    best_pos = AW'(left_c);
    if (has_r_r && first(rd_data, lft_r)) begin
      best = rd_data;
      best_pos = AW'(right_c);
    end
  end

  always_comb begin
    rd_addr = addr(q_r, pos_r);
    wr_en   = 1'b0;
    wr_addr = addr(q_r, pos_r);
    wr_data = cur_r;
    pos_nxt = pos_r;
    unique case (state_r)
      S_IDLE: rd_addr = addr(sel_q, '0);
      S_UP_RD: begin
        rd_addr = addr(q_r, parent);
        wr_en = (pos_r == '0);
      end
      S_UP_WAIT: rd_addr = addr(q_r, parent);
      S_UP_CMP: begin
        if (first(cur_r, rd_data)) begin
          wr_en = 1'b1;
          wr_data = rd_data;
          pos_nxt = parent;
        end else begin
          wr_en = 1'b1;
        end
      end
      S_DN_LAST:  rd_addr = addr(q_r, AW'(n_r));
      S_DN_RDL:   rd_addr = addr(q_r, AW'(left_c));
      S_DN_RDR:   rd_addr = addr(q_r, AW'(right_c));
      S_DN_WAITR: rd_addr = addr(q_r, AW'(right_c));
      S_DN_CMP: begin
        if (first(best, cur_r)) begin
          wr_en = 1'b1;
          wr_data = best;
          pos_nxt = best_pos;
        end
      end
      S_DN_FIN: wr_en = (n_r != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_id_r   <= (ID_BITS+1)'(1);
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            q_r      <= sel_q;
            status_r <= ST_OK;
            id_r     <= '0;
            unique case (mode_t'(in_mode))
              MODE_INSERT: begin
                if (next_id_r > (ID_BITS+1)'((1 << ID_BITS) - 1)) begin
                  status_r <= ST_EXHAUSTED;
                  out_valid_r <= 1'b1;
                end else if (32'(cnt_sel) >= QUEUE_DEPTH) begin
                  status_r <= ST_FULL;
                  out_valid_r <= 1'b1;
                end else begin
                  pos_r <= AW'(cnt_sel);
                  cur_r.prio <= PRIO_BITS'(in_priority_req);
                  cur_r.id <= next_id_r[ID_BITS-1:0];
                  id_r <= 16'(next_id_r[ID_BITS-1:0]);
                  next_id_r <= next_id_r + 1'b1;
                  cnt_r[sel_q] <= cnt_sel + 1'b1;
                end
              end
              MODE_REMOVE: begin
                if (cnt_sel == '0) begin
                  status_r <= ST_EMPTY;
                  out_valid_r <= 1'b1;
                end else begin
                  pos_r <= '0;
                  n_r <= cnt_sel - 1'b1;
                  cnt_r[sel_q] <= cnt_sel - 1'b1;
                end
              end
              MODE_CLEAR: begin
                for (int i = 0; i < NUM_QUEUES; i++) cnt_r[i] <= '0;
                next_id_r <= (ID_BITS+1)'(1);
                out_valid_r <= 1'b1;
              end
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_UP_RD: begin
          if (pos_r == '0) out_valid_r <= 1'b1;
        end
        S_UP_CMP: begin
          pos_r <= pos_nxt;
          if (!first(cur_r, rd_data)) out_valid_r <= 1'b1;
        end
        S_DN_LAST: id_r <= 16'(rd_data.id);
        S_DN_LWAIT: cur_r <= rd_data;
        S_DN_RDL: ;
        S_DN_RDR: begin
          has_r_r <= has_r;
          lft_r <= rd_data;
        end
        S_DN_CMP: begin
          if (first(best, cur_r)) pos_r <= pos_nxt;
        end
        S_DN_FIN: out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule
